// ===== rtl/dtcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtcs_pkg
// Shared types, codes and reset values for the day/thermal channel switcher.
// ----------------------------------------------------------------------------
package dtcs_pkg;

    localparam int TIMER_BITS_DEF = 32;

    localparam int LUX_W  = 18;
    localparam int CON_W  = 16;
    localparam int DT_W   = 16;
    localparam int MS_W   = 32;
    localparam int CH_W   = 2;
    localparam int CAUSE_W = 2;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 16;

    // Channel codes
    localparam logic [CH_W-1:0] CH_PRIMARY   = 2'd0;
    localparam logic [CH_W-1:0] CH_SECONDARY = 2'd1;
    localparam logic [CH_W-1:0] CH_AUX       = 2'd2;
    localparam logic [CH_W-1:0] CH_INVALID   = 2'd3;

    // Item kinds
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    // Switch causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_MANUAL   = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_THERMAL  = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_DAYLIGHT = 2'd3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_AUTO_ENABLE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LIGHT_LUX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DAYLIGHT_LUX  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOW_CONTRAST  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HYSTERESIS_MS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COOLDOWN_MS   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_ZOOM_EN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CAMERA_PRES   = 3'd7;

    // Register reset values
    localparam logic             RST_AUTO_ENABLE   = 1'b0;
    localparam logic [LUX_W-1:0] RST_LOW_LIGHT_LUX = 18'd10;
    localparam logic [LUX_W-1:0] RST_DAYLIGHT_LUX  = 18'd50;
    localparam logic [CON_W-1:0] RST_LOW_CONTRAST  = 16'd64;
    localparam logic [MS_W-1:0]  RST_HYSTERESIS_MS = 32'd3000;
    localparam logic [MS_W-1:0]  RST_COOLDOWN_MS   = 32'd10000;
    localparam logic             RST_MATCH_ZOOM_EN = 1'b1;
    localparam logic [1:0]       RST_CAMERA_PRES   = 2'b11;

    typedef struct packed {
        logic             auto_enable;
        logic [LUX_W-1:0] low_light_lux;
        logic [LUX_W-1:0] daylight_return_lux;
        logic [CON_W-1:0] low_contrast_q8;
        logic [MS_W-1:0]  hysteresis_ms;
        logic [MS_W-1:0]  cooldown_ms;
        logic             match_zoom_enable;
        logic [1:0]       camera_present;
    } t_cfg;

    typedef struct packed {
        logic             func;
        logic [DT_W-1:0]  dt_ms;
        logic [LUX_W-1:0] ambient_lux;
        logic [CON_W-1:0] contrast_q8;
        logic             smoke_haze;
        logic [CH_W-1:0]  select_channel;
        logic             want_match_zoom;
    } t_item;

    typedef struct packed {
        logic [CH_W-1:0]    active_now;
        logic               accepted;
        logic               switched;
        logic [CH_W-1:0]    previous_channel;
        logic [CAUSE_W-1:0] switch_cause;
        logic               match_zoom_request;
    } t_result;

    // Auxiliary runs on whichever camera is fitted.
    function automatic logic cam_for(input logic [CH_W-1:0] ch, input logic [1:0] present);
        logic r;
        case (ch)
            CH_PRIMARY:   r = present[0];
            CH_SECONDARY: r = present[1];
            CH_AUX:       r = present[0] | present[1];
            default:      r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dtcs_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtcs_cfg
// Configuration register file with timer clear on writes to the auto registers.
// ----------------------------------------------------------------------------
module dtcs_cfg
    import dtcs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [REG_IDX_W-1:0]  i_index,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                       o_cfg,
    output logic                       o_timer_clear
);

    t_cfg r_cfg;
    logic w_write;

    assign o_ready = 1'b1;
    assign w_write = i_valid & o_ready;
    assign o_cfg   = r_cfg;
    assign o_timer_clear = w_write &&
                           (i_index inside {[REG_AUTO_ENABLE:REG_COOLDOWN_MS]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_enable         <= RST_AUTO_ENABLE;
            r_cfg.low_light_lux       <= RST_LOW_LIGHT_LUX;
            r_cfg.daylight_return_lux <= RST_DAYLIGHT_LUX;
            r_cfg.low_contrast_q8     <= RST_LOW_CONTRAST;
            r_cfg.hysteresis_ms       <= RST_HYSTERESIS_MS;
            r_cfg.cooldown_ms         <= RST_COOLDOWN_MS;
            r_cfg.match_zoom_enable   <= RST_MATCH_ZOOM_EN;
            r_cfg.camera_present      <= RST_CAMERA_PRES;
        end else if (w_write) begin
            case (i_index)
                REG_AUTO_ENABLE:   r_cfg.auto_enable         <= i_data[0];
                REG_LOW_LIGHT_LUX: r_cfg.low_light_lux       <= i_data[LUX_W-1:0];
                REG_DAYLIGHT_LUX:  r_cfg.daylight_return_lux <= i_data[LUX_W-1:0];
                REG_LOW_CONTRAST:  r_cfg.low_contrast_q8     <= i_data[CON_W-1:0];
                REG_HYSTERESIS_MS: r_cfg.hysteresis_ms       <= i_data[MS_W-1:0];
                REG_COOLDOWN_MS:   r_cfg.cooldown_ms         <= i_data[MS_W-1:0];
                REG_MATCH_ZOOM_EN: r_cfg.match_zoom_enable   <= i_data[0];
                REG_CAMERA_PRES:   r_cfg.camera_present      <= i_data[1:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dtcs_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtcs_in_reg
// Input register: unpacks a stream transfer into an item and holds it.
// ----------------------------------------------------------------------------
module dtcs_in_reg
    import dtcs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [IN_TDATA_W-1:0] i_tdata,
    input  wire logic                  i_tuser,
    input  wire logic                  i_take,
    output logic                       o_valid,
    output t_item                      o_item
);

    logic  r_valid;
    t_item r_item;
    t_item w_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        w_item.func            = i_tuser;
        w_item.dt_ms           = i_tdata[15:0];
        w_item.ambient_lux     = i_tdata[33:16];
        w_item.contrast_q8     = i_tdata[49:34];
        w_item.smoke_haze      = i_tdata[50];
        w_item.select_channel  = i_tdata[52:51];
        w_item.want_match_zoom = i_tdata[53];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= w_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dtcs_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtcs_engine
// Switching state, single-pass decision logic and the result register.
// ----------------------------------------------------------------------------
module dtcs_engine
    import dtcs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_timer_clear,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_take,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_result
);

    localparam int CW = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;

    logic [CH_W-1:0]       r_active, n_active;
    logic                  r_pend, n_pend;
    logic [TIMER_BITS-1:0] r_dwell, n_dwell;
    logic [TIMER_BITS-1:0] r_cool, n_cool;
    logic                  r_out_valid;
    t_result               r_res, n_res;

    logic [TIMER_BITS-1:0] w_dt;
    logic [TIMER_BITS-1:0] w_dwell_base;
    logic [TIMER_BITS:0]   w_sum;
    logic [CW-1:0]         w_cool_w;
    logic [CW-1:0]         w_tmax_w;
    logic [TIMER_BITS-1:0] w_cool_load;
    logic                  w_to_thermal;
    logic [CH_W-1:0]       w_target;
    logic                  w_cond;
    logic                  w_both;

    assign o_take   = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_res;

    assign w_dt        = TIMER_BITS'(i_item.dt_ms);
    assign w_cool_w    = CW'(i_cfg.cooldown_ms);
    assign w_tmax_w    = CW'({TIMER_BITS{1'b1}});
    assign w_cool_load = TIMER_BITS'((w_cool_w > w_tmax_w) ? w_tmax_w : w_cool_w);
    assign w_both      = (i_cfg.camera_present == 2'b11);
    assign w_to_thermal = (r_active == CH_PRIMARY);
    assign w_target    = w_to_thermal ? CH_SECONDARY : CH_PRIMARY;

    always_comb begin
        if (w_to_thermal) begin
            w_cond = (i_item.ambient_lux < i_cfg.low_light_lux) ||
                     (i_item.contrast_q8 < i_cfg.low_contrast_q8) ||
                     i_item.smoke_haze;
        end else begin
            w_cond = (i_item.ambient_lux >= i_cfg.daylight_return_lux) &&
                     (i_item.contrast_q8 >= i_cfg.low_contrast_q8) &&
                     !i_item.smoke_haze;
        end
    end

    assign w_dwell_base = (r_pend != w_to_thermal) ? '0 : r_dwell;
    assign w_sum        = {1'b0, w_dwell_base} + {1'b0, w_dt};

    always_comb begin
        n_active = r_active;
        n_pend   = r_pend;
        n_dwell  = r_dwell;
        n_cool   = r_cool;
        n_res.active_now         = r_active;
        n_res.accepted           = 1'b1;
        n_res.switched           = 1'b0;
        n_res.previous_channel   = r_active;
        n_res.switch_cause       = CAUSE_NONE;
        n_res.match_zoom_request = 1'b0;
        if (i_item.func == FUNC_SELECT) begin
            if ((i_item.select_channel == CH_INVALID) ||
                ((i_item.select_channel != r_active) &&
                 !cam_for(i_item.select_channel, i_cfg.camera_present))) begin
                n_res.accepted = 1'b0;
            end else if (i_item.select_channel != r_active) begin
                n_res.match_zoom_request = i_item.want_match_zoom &&
                    i_cfg.match_zoom_enable && cam_for(r_active, i_cfg.camera_present);
                n_active             = i_item.select_channel;
                n_res.switched       = 1'b1;
                n_res.switch_cause   = CAUSE_MANUAL;
            end
        end else if (i_cfg.auto_enable) begin
            if (r_cool != '0) begin
                n_cool = (r_cool > w_dt) ? (r_cool - w_dt) : '0;
            end else if ((r_active == CH_PRIMARY) || (r_active == CH_SECONDARY)) begin
                if (w_cond) begin
                    n_pend  = w_to_thermal;
                    n_dwell = w_sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : w_sum[TIMER_BITS-1:0];
                    if ((CW'(n_dwell) >= CW'(i_cfg.hysteresis_ms)) &&
                        cam_for(w_target, i_cfg.camera_present)) begin
                        n_active = w_target;
                        n_cool   = w_cool_load;
                        n_dwell  = '0;
                        n_res.switched = 1'b1;
                        n_res.switch_cause = w_to_thermal ? CAUSE_THERMAL : CAUSE_DAYLIGHT;
                        n_res.match_zoom_request = i_cfg.match_zoom_enable && w_both;
                    end
                end else begin
                    n_dwell = '0;
                    n_pend  = r_active[0];
                end
            end
        end
        n_res.active_now = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= CH_PRIMARY;
            r_pend      <= 1'b0;
            r_dwell     <= '0;
            r_cool      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_timer_clear) begin
                r_dwell <= '0;
                r_cool  <= '0;
            end else if (o_take) begin
                r_dwell <= n_dwell;
                r_cool  <= n_cool;
            end
            if (o_take) begin
                r_active <= n_active;
                r_pend   <= n_pend;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    a_switch_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.switched) |-> (r_res.active_now != r_res.previous_channel))
        else $error("Switch reported without a change of channel.");

    a_no_switch_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.switched) |->
        ((r_res.active_now == r_res.previous_channel) && (r_res.switch_cause == CAUSE_NONE)
         && !r_res.match_zoom_request))
        else $error("Channel or cause changed without a switch.");

    a_reject_no_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.accepted) |-> !r_res.switched)
        else $error("Rejected select still switched.");

    a_clear_timers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_timer_clear |=> ((r_dwell == '0) && (r_cool == '0)))
        else $error("Timers not cleared after an auto register write.");

endmodule
`default_nettype wire

// ===== rtl/day_thermal_channel_switcher_core.sv =====
`default_nettype none
// A result is offered once its input has passed the input register and the result
// register.
// Throughput: one item per cycle while m_axis_tready is high; the input register and the
// result register keep both sides moving, and the stall path runs from m_axis_tready back to s_axis_tready.
// Reset (synchronous, active low) selects the primary channel, clears both timers and
// the pending target, and restores every configuration register to its default.
// ----------------------------------------------------------------------------
// day_thermal_channel_switcher_core
// Top level: chooses between daylight, thermal and auxiliary camera channels.
// ----------------------------------------------------------------------------
module day_thermal_channel_switcher_core
    import dtcs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // dt_ms[15:0], ambient_lux[33:16], contrast_q8[49:34], smoke_haze[50],
    // select_channel[52:51], want_match_zoom[53], zero[55:54]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // active_now[1:0], accepted[2], switched[3], previous_channel[5:4],
    // switch_cause[7:6], match_zoom_request[8], zero[15:9]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [REG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    w_cfg;
    logic    w_timer_clear;
    logic    w_item_valid;
    t_item   w_item;
    logic    w_take;
    t_result w_res;

    dtcs_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_cfg_valid),
        .o_ready       (o_cfg_ready),
        .i_index       (i_cfg_index),
        .i_data        (i_cfg_data),
        .o_cfg         (w_cfg),
        .o_timer_clear (w_timer_clear)
    );

    dtcs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    dtcs_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_timer_clear (w_timer_clear),
        .i_valid       (w_item_valid),
        .i_item        (w_item),
        .o_take        (w_take),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_result      (w_res)
    );

    assign m_axis_tdata = {7'b0, w_res.match_zoom_request, w_res.switch_cause,
                           w_res.previous_channel, w_res.switched, w_res.accepted,
                           w_res.active_now};

endmodule
`default_nettype wire

// ===== sim/day_thermal_channel_switcher_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// day_thermal_channel_switcher_core_tb
// Self-checking bench for the camera channel switcher. A scene stream of ticks
// and manual selects is pushed through the input port while a local model of
// the channel, dwell and cooldown state predicts every result transfer. The
// run covers directed corner cases, several register settings with random
// scene runs and a long receiver hold-off.
// ----------------------------------------------------------------------------
module day_thermal_channel_switcher_core_tb;
    import dtcs_pkg::*;

    localparam int          RUN_LIMIT  = 200_000;
    localparam int          HOLD_AT    = 250;
    localparam int          HOLD_LEN   = 200;
    localparam logic [17:0] LUX_MAX    = 18'h3FFFF;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [REG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    day_thermal_channel_switcher_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the switcher configuration and state.
    logic             cfg_auto     = RST_AUTO_ENABLE;
    logic [LUX_W-1:0] cfg_low_lux  = RST_LOW_LIGHT_LUX;
    logic [LUX_W-1:0] cfg_day_lux  = RST_DAYLIGHT_LUX;
    logic [CON_W-1:0] cfg_low_con  = RST_LOW_CONTRAST;
    logic [MS_W-1:0]  cfg_hyst_ms  = RST_HYSTERESIS_MS;
    logic [MS_W-1:0]  cfg_cool_ms  = RST_COOLDOWN_MS;
    logic             cfg_zoom_en  = RST_MATCH_ZOOM_EN;
    logic [1:0]       cfg_cameras  = RST_CAMERA_PRES;
    logic [CH_W-1:0]  live_channel = CH_PRIMARY;
    logic             pending_tgt  = 1'b0;
    logic [31:0]      dwell_ms     = '0;
    logic [31:0]      cooldown_ms  = '0;

    t_item   scene_items[$];
    t_result channel_reports_due[$];
    t_item   in_flight;

    bit idle_on         = 1'b1;
    int gap_left        = 0;
    int stall_left      = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    int items_accepted  = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int settings_used   = 0;
    int cycle_count     = 0;

    function automatic logic camera_fitted(input logic [CH_W-1:0] ch);
        case (ch)
            CH_PRIMARY:   return cfg_cameras[0];
            CH_SECONDARY: return cfg_cameras[1];
            CH_AUX:       return |cfg_cameras;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic t_result predict_channel_step(input t_item it);
        t_result         r;
        logic [CH_W-1:0] prev;
        logic [CH_W-1:0] target;
        logic            to_thermal;
        logic            cond;
        logic [32:0]     sum;
        prev = live_channel;
        r = '0;
        r.accepted = 1'b1;
        r.previous_channel = prev;
        if (it.func == FUNC_SELECT) begin
            if (it.select_channel == CH_INVALID ||
                (it.select_channel != prev && !camera_fitted(it.select_channel))) begin
                r.accepted = 1'b0;
            end else if (it.select_channel != prev) begin
                r.match_zoom_request = it.want_match_zoom && cfg_zoom_en && camera_fitted(prev);
                live_channel = it.select_channel;
                r.switched = 1'b1;
                r.switch_cause = CAUSE_MANUAL;
            end
        end else if (cfg_auto) begin
            if (cooldown_ms != 0) begin
                cooldown_ms = (cooldown_ms > it.dt_ms) ? cooldown_ms - it.dt_ms : '0;
            end else if (prev == CH_PRIMARY || prev == CH_SECONDARY) begin
                to_thermal = (prev == CH_PRIMARY);
                target = to_thermal ? CH_SECONDARY : CH_PRIMARY;
                if (to_thermal) begin
                    cond = it.ambient_lux < cfg_low_lux || it.contrast_q8 < cfg_low_con ||
                           it.smoke_haze;
                end else begin
                    cond = it.ambient_lux >= cfg_day_lux && it.contrast_q8 >= cfg_low_con &&
                           !it.smoke_haze;
                end
                if (cond) begin
                    if (pending_tgt != target[0]) begin
                        pending_tgt = target[0];
                        dwell_ms = '0;
                    end
                    sum = {1'b0, dwell_ms} + it.dt_ms;
                    dwell_ms = sum[32] ? '1 : sum[31:0];
                    if (dwell_ms >= cfg_hyst_ms && camera_fitted(target)) begin
                        live_channel = target;
                        cooldown_ms = cfg_cool_ms;
                        dwell_ms = '0;
                        r.switched = 1'b1;
                        r.switch_cause = to_thermal ? CAUSE_THERMAL : CAUSE_DAYLIGHT;
                        r.match_zoom_request = cfg_zoom_en && (cfg_cameras == 2'b11);
                    end
                end else begin
                    dwell_ms = '0;
                    pending_tgt = prev[0];
                end
            end
        end
        r.active_now = live_channel;
        return r;
    endfunction

    function automatic t_item scene_tick(input logic [DT_W-1:0] dt, input logic [LUX_W-1:0] lux,
                                         input logic [CON_W-1:0] con, input logic smoke);
        t_item it;
        it.func            = FUNC_TICK;
        it.dt_ms           = dt;
        it.ambient_lux     = lux;
        it.contrast_q8     = con;
        it.smoke_haze      = smoke;
        it.select_channel  = CH_W'($urandom_range(0, 3));
        it.want_match_zoom = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_item manual_pick(input logic [CH_W-1:0] ch, input logic want);
        t_item it;
        it = scene_tick(DT_W'($urandom), LUX_W'($urandom), CON_W'($urandom),
                        1'($urandom_range(0, 1)));
        it.func            = FUNC_SELECT;
        it.select_channel  = ch;
        it.want_match_zoom = want;
        return it;
    endfunction

    // Scene kinds: dark, daylight, smoke, low contrast, anything.
    function automatic t_item random_tick(input int kind);
        t_item it;
        it = scene_tick(DT_W'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3000)),
                        LUX_W'($urandom), CON_W'($urandom), 1'($urandom_range(0, 1)));
        case (kind)
            0: if (cfg_low_lux != 0)
                   it.ambient_lux = LUX_W'($urandom_range(0, cfg_low_lux - 1));
            1: begin
                it.ambient_lux = LUX_W'($urandom_range(cfg_day_lux, LUX_MAX));
                it.contrast_q8 = CON_W'($urandom_range(cfg_low_con, 16'hFFFF));
                it.smoke_haze  = 1'b0;
            end
            2: it.smoke_haze = 1'b1;
            3: if (cfg_low_con != 0)
                   it.contrast_q8 = CON_W'($urandom_range(0, cfg_low_con - 1));
            default: ;
        endcase
        return it;
    endfunction

    task automatic queue_random_phase(input int count);
        int made;
        int run;
        int kind;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 6) == 0) begin
                scene_items.push_back(manual_pick(CH_W'($urandom_range(0, 3)),
                                                  1'($urandom_range(0, 1))));
                made++;
            end else begin
                kind = $urandom_range(0, 4);
                run  = $urandom_range(1, 12);
                repeat (run) scene_items.push_back(random_tick(kind));
                made += run;
            end
        end
    endtask

    task automatic settle_idle();
        while (scene_items.size() != 0 || s_axis_tvalid || channel_reports_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_AUTO_ENABLE:   cfg_auto    = val[0];
            REG_LOW_LIGHT_LUX: cfg_low_lux = val[LUX_W-1:0];
            REG_DAYLIGHT_LUX:  cfg_day_lux = val[LUX_W-1:0];
            REG_LOW_CONTRAST:  cfg_low_con = val[CON_W-1:0];
            REG_HYSTERESIS_MS: cfg_hyst_ms = val;
            REG_COOLDOWN_MS:   cfg_cool_ms = val;
            REG_MATCH_ZOOM_EN: cfg_zoom_en = val[0];
            REG_CAMERA_PRES:   cfg_cameras = val[1:0];
            default: ;
        endcase
        if (idx <= REG_COOLDOWN_MS) begin
            dwell_ms    = '0;
            cooldown_ms = '0;
        end
        @(posedge i_clk);
    endtask

    task automatic set_registers(input logic auto_en, input logic [LUX_W-1:0] low_lux,
                                 input logic [LUX_W-1:0] day_lux, input logic [CON_W-1:0] con,
                                 input logic [MS_W-1:0] hyst, input logic [MS_W-1:0] cool,
                                 input logic zoom_en, input logic [1:0] cams);
        write_reg(REG_AUTO_ENABLE,   CFG_DATA_W'(auto_en));
        write_reg(REG_LOW_LIGHT_LUX, CFG_DATA_W'(low_lux));
        write_reg(REG_DAYLIGHT_LUX,  CFG_DATA_W'(day_lux));
        write_reg(REG_LOW_CONTRAST,  CFG_DATA_W'(con));
        write_reg(REG_HYSTERESIS_MS, CFG_DATA_W'(hyst));
        write_reg(REG_COOLDOWN_MS,   CFG_DATA_W'(cool));
        write_reg(REG_MATCH_ZOOM_EN, CFG_DATA_W'(zoom_en));
        write_reg(REG_CAMERA_PRES,   CFG_DATA_W'(cams));
        settings_used++;
    endtask

    task automatic compare_field(input string name, input logic [1:0] want,
                                 input logic [1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_report(input t_result want, input logic [OUT_TDATA_W-1:0] got);
        compare_field("active_now",         want.active_now,             got[1:0]);
        compare_field("accepted",           2'(want.accepted),           2'(got[2]));
        compare_field("switched",           2'(want.switched),           2'(got[3]));
        compare_field("previous_channel",   want.previous_channel,       got[5:4]);
        compare_field("switch_cause",       want.switch_cause,           got[7:6]);
        compare_field("match_zoom_request", 2'(want.match_zoom_request), 2'(got[8]));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                channel_reports_due.push_back(predict_channel_step(in_flight));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 11) == 0) begin
                    gap_left      <= $urandom_range(0, 8);
                    s_axis_tvalid <= 1'b0;
                end else if (scene_items.size() != 0) begin
                    in_flight      = scene_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= in_flight.func;
                    s_axis_tdata  <= {2'b00, in_flight.want_match_zoom, in_flight.select_channel,
                                      in_flight.smoke_haze, in_flight.contrast_q8,
                                      in_flight.ambient_lux, in_flight.dt_ms};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_checked++;
                if (channel_reports_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             m_axis_tdata);
                end else begin
                    check_report(channel_reports_due.pop_front(), m_axis_tdata);
                end
            end
            if (stall_left != 0)
                stall_left <= stall_left - 1;
            else if (idle_on && $urandom_range(0, 12) == 0)
                stall_left <= $urandom_range(1, 9);
            m_axis_tready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // One long receiver hold-off so that the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_checked >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("day_thermal_channel_switcher_core_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Automatic switching off: ticks change nothing, manual selects cover every code.
        scene_items.push_back(scene_tick(16'hFFFF, '0, '0, 1'b1));
        scene_items.push_back(manual_pick(CH_SECONDARY, 1'b1));
        scene_items.push_back(manual_pick(CH_SECONDARY, 1'b0));
        scene_items.push_back(manual_pick(CH_INVALID, 1'b1));
        scene_items.push_back(manual_pick(CH_AUX, 1'b0));
        scene_items.push_back(manual_pick(CH_PRIMARY, 1'b1));
        settle_idle();

        // Secondary camera missing: thermal is refused, auxiliary is still accepted with only the primary fitted.
        write_reg(REG_CAMERA_PRES, 32'd1);
        scene_items.push_back(manual_pick(CH_SECONDARY, 1'b1));
        scene_items.push_back(manual_pick(CH_AUX, 1'b1));
        scene_items.push_back(manual_pick(CH_PRIMARY, 1'b0));
        settle_idle();

        // Dwell keeps counting while the thermal camera is absent.
        set_registers(1'b1, 18'd10, 18'd50, 16'd64, 32'd100, 32'd50, 1'b1, 2'b01);
        scene_items.push_back(scene_tick(16'd200, '0, 16'hFFFF, 1'b0));
        settle_idle();

        write_reg(REG_CAMERA_PRES, 32'd3);
        scene_items.push_back(scene_tick(16'd0, LUX_MAX, '0, 1'b0));
        scene_items.push_back(scene_tick(16'd30, '0, '0, 1'b1));
        scene_items.push_back(scene_tick(16'hFFFF, LUX_MAX, 16'hFFFF, 1'b0));
        scene_items.push_back(scene_tick(16'd60, LUX_MAX, 16'hFFFF, 1'b0));
        scene_items.push_back(scene_tick(16'd10, '0, 16'hFFFF, 1'b0));
        scene_items.push_back(scene_tick(16'd60, LUX_MAX, 16'hFFFF, 1'b0));
        scene_items.push_back(scene_tick(16'd40, 18'd50, 16'd64, 1'b0));
        scene_items.push_back(scene_tick(16'hFFFF, '0, '0, 1'b1));
        scene_items.push_back(scene_tick(16'd100, 18'd9, 16'hFFFF, 1'b0));
        scene_items.push_back(manual_pick(CH_AUX, 1'b1));
        scene_items.push_back(scene_tick(16'hFFFF, '0, '0, 1'b1));
        scene_items.push_back(scene_tick(16'd500, '0, '0, 1'b1));
        scene_items.push_back(manual_pick(CH_PRIMARY, 1'b1));
        settle_idle();

        for (int p = 0; p < 6; p++) begin
            idle_on = (p != 1) && (p != 5);
            case (p)
                0: set_registers(1'b1, 18'd1000, 18'd5000, 16'h0100, 32'd8000, 32'd6000,
                                 1'b1, 2'b11);
                1: set_registers(1'b1, LUX_MAX, '0, '0, '0, '0, 1'b0,
                                 2'($urandom_range(0, 3)));
                2: set_registers(1'b1, '0, LUX_MAX, 16'hFFFF, '0, 32'hFFFF_FFFF, 1'b1, 2'b11);
                3: set_registers(1'($urandom_range(0, 1)), LUX_W'($urandom_range(0, 3000)),
                                 LUX_W'($urandom_range(0, 8000)),
                                 CON_W'($urandom_range(0, 1024)),
                                 32'hFFFF_FFFF, MS_W'($urandom_range(0, 20000)),
                                 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                default: set_registers($urandom_range(0, 3) != 0,
                                       LUX_W'($urandom_range(0, 3000)),
                                       LUX_W'($urandom_range(0, 8000)),
                                       CON_W'($urandom_range(0, 1024)),
                                       MS_W'($urandom_range(0, 30000)),
                                       MS_W'($urandom_range(0, 20000)),
                                       1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            endcase
            queue_random_phase(145);
            settle_idle();
        end
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d scene items and %0d results over %0d register settings,",
                 items_accepted, results_checked, settings_used);
        $display("including directed corner cases and a long receiver hold-off; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("day_thermal_channel_switcher_core_tb: clean");
        else
            $display("day_thermal_channel_switcher_core_tb: errors");
        $finish;
    end

endmodule

// ===== day_thermal_channel_switcher_core.f =====
rtl/dtcs_pkg.sv
rtl/dtcs_cfg.sv
rtl/dtcs_in_reg.sv
rtl/dtcs_engine.sv
rtl/day_thermal_channel_switcher_core.sv
sim/day_thermal_channel_switcher_core_tb.sv
